>>> rtl/core/jvsc_pkg.sv
package jvsc_pkg;

	localparam int unsigned MAX_DEPTH_DEF = 255;

	localparam int unsigned PHASE_W = 4;
	localparam int unsigned ERR_W   = 3;
	localparam int unsigned LCH_W   = 2;
	localparam int unsigned LPOS_W  = 3;

	typedef logic [7:0]         byte_t;
	typedef logic [ERR_W-1:0]   err_t;
	typedef logic [LCH_W-1:0]   lit_choice_t;
	typedef logic [LPOS_W-1:0]  lit_pos_t;

	localparam err_t ERR_OK     = 3'd0;
	localparam err_t ERR_EMPTY  = 3'd1;
	localparam err_t ERR_VALUE  = 3'd2;
	localparam err_t ERR_EXTRA  = 3'd3;
	localparam err_t ERR_UNTERM = 3'd4;
	localparam err_t ERR_DEPTH  = 3'd5;

	localparam lit_choice_t LIT_TRUE  = 2'd0;
	localparam lit_choice_t LIT_FALSE = 2'd1;
	localparam lit_choice_t LIT_NULL  = 2'd2;

	localparam byte_t CH_QUOTE   = 8'h22;
	localparam byte_t CH_BSLASH  = 8'h5C;
	localparam byte_t CH_LBRACE  = 8'h7B;
	localparam byte_t CH_RBRACE  = 8'h7D;
	localparam byte_t CH_LBRACK  = 8'h5B;
	localparam byte_t CH_RBRACK  = 8'h5D;
	localparam byte_t CH_MINUS   = 8'h2D;
	localparam byte_t CH_PLUS    = 8'h2B;
	localparam byte_t CH_DOT     = 8'h2E;
	localparam byte_t CH_E_LO    = 8'h65;
	localparam byte_t CH_E_UP    = 8'h45;
	localparam byte_t CH_T       = 8'h74;
	localparam byte_t CH_F       = 8'h66;
	localparam byte_t CH_N       = 8'h6E;
	localparam byte_t CH_NUL     = 8'h00;

	function automatic logic is_ws(input byte_t c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_digit(input byte_t c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	// Expected character of a literal at a given position; NUL past its end.
	function automatic byte_t lit_char(input lit_choice_t ch, input lit_pos_t pos);
		byte_t r;
		r = CH_NUL;
		case (ch)
			LIT_TRUE: begin
				case (pos)
					3'd0: r = 8'h74;
					3'd1: r = 8'h72;
					3'd2: r = 8'h75;
					3'd3: r = 8'h65;
					default: r = CH_NUL;
				endcase
			end
			LIT_FALSE: begin
				case (pos)
					3'd0: r = 8'h66;
					3'd1: r = 8'h61;
					3'd2: r = 8'h6C;
					3'd3: r = 8'h73;
					3'd4: r = 8'h65;
					default: r = CH_NUL;
				endcase
			end
			default: begin
				case (pos)
					3'd0: r = 8'h6E;
					3'd1: r = 8'h75;
					3'd2: r = 8'h6C;
					3'd3: r = 8'h6C;
					default: r = CH_NUL;
				endcase
			end
		endcase
		return r;
	endfunction

	function automatic lit_pos_t lit_len(input lit_choice_t ch);
		return (ch == LIT_FALSE) ? 3'd5 : 3'd4;
	endfunction

endpackage

>>> rtl/core/json_value_structure_checker_top.sv
// Checks that a byte stream is one JSON value (string, object, array, literal or
// number, with surrounding whitespace). While in_ready is high, one byte is taken per
// clock with no bubbles; the scan state is a set of registers updated from the accepted
// byte. A transaction with end_of_text set, or a zero byte, closes the document; its verdict
// (is_valid, error_code) is on the output in the next cycle and the scanner restarts on a
// fresh document. Other transactions produce no output. The output register holds
// one verdict; while it is held and out_ready is low, in_ready is low and every
// input transaction stalls, terminator or not. With out_ready high the input never
// stalls. Objects and arrays count only their own bracket kind, up to MAX_DEPTH levels.
module json_value_structure_checker_top
	import jvsc_pkg::*;
#(
	parameter int unsigned MAX_DEPTH = MAX_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_valid,
	output logic [2:0] error_code
);

	localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);
	localparam logic [DEPTH_W-1:0] MAX_CNT = DEPTH_W'(MAX_DEPTH);
	localparam logic [DEPTH_W-1:0] CNT_ONE = DEPTH_W'(1);

	localparam logic [PHASE_W-1:0] PH_LEAD     = 4'd0;
	localparam logic [PHASE_W-1:0] PH_STR      = 4'd1;
	localparam logic [PHASE_W-1:0] PH_STR_ESC  = 4'd2;
	localparam logic [PHASE_W-1:0] PH_CONT     = 4'd3;
	localparam logic [PHASE_W-1:0] PH_CSTR     = 4'd4;
	localparam logic [PHASE_W-1:0] PH_CSTR_ESC = 4'd5;
	localparam logic [PHASE_W-1:0] PH_LIT      = 4'd6;
	localparam logic [PHASE_W-1:0] PH_NUM_INT  = 4'd7;
	localparam logic [PHASE_W-1:0] PH_NUM_FRAC = 4'd8;
	localparam logic [PHASE_W-1:0] PH_NUM_EXPS = 4'd9;
	localparam logic [PHASE_W-1:0] PH_NUM_EXP  = 4'd10;
	localparam logic [PHASE_W-1:0] PH_TRAIL    = 4'd11;
	localparam logic [PHASE_W-1:0] PH_ERROR    = 4'd12;

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic               is_array_q, is_array_d;
	logic [DEPTH_W-1:0] depth_q, depth_d;
	lit_choice_t        lit_ch_q, lit_ch_d;
	lit_pos_t           lit_pos_q, lit_pos_d;
	err_t               pend_err_q, pend_err_d;

	logic  out_valid_q;
	logic  is_valid_q;
	err_t  error_code_q;

	logic  in_fire;
	logic  term;
	err_t  final_code;
	byte_t c;
	byte_t open_c;
	byte_t close_c;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign c         = text_byte;
	assign term      = end_of_text || (c == CH_NUL);
	assign open_c    = is_array_q ? CH_LBRACK : CH_LBRACE;
	assign close_c   = is_array_q ? CH_RBRACK : CH_RBRACE;

	always_comb begin
		unique case (phase_q)
			PH_LEAD: final_code = ERR_EMPTY;
			PH_STR, PH_STR_ESC, PH_CONT, PH_CSTR, PH_CSTR_ESC: final_code = ERR_UNTERM;
			PH_LIT: final_code = ERR_VALUE;
			PH_NUM_INT, PH_NUM_FRAC, PH_NUM_EXPS, PH_NUM_EXP, PH_TRAIL: final_code = ERR_OK;
			default: final_code = pend_err_q;
		endcase
	end

	always_comb begin
		phase_d    = phase_q;
		is_array_d = is_array_q;
		depth_d    = depth_q;
		lit_ch_d   = lit_ch_q;
		lit_pos_d  = lit_pos_q;
		pend_err_d = pend_err_q;
		if (term) begin
			phase_d    = PH_LEAD;
			is_array_d = 1'b0;
			depth_d    = '0;
			lit_ch_d   = LIT_TRUE;
			lit_pos_d  = '0;
			pend_err_d = ERR_OK;
		end else begin
			unique case (phase_q)
				PH_LEAD: begin
					if (!is_ws(c)) begin
						if (c == CH_QUOTE) begin
							phase_d = PH_STR;
						end else if (c == CH_LBRACE || c == CH_LBRACK) begin
							is_array_d = (c == CH_LBRACK);
							depth_d    = CNT_ONE;
							phase_d    = PH_CONT;
						end else if (c == CH_T || c == CH_F || c == CH_N) begin
							lit_ch_d  = (c == CH_T) ? LIT_TRUE :
							            (c == CH_F) ? LIT_FALSE : LIT_NULL;
							lit_pos_d = 3'd1;
							phase_d   = PH_LIT;
						end else if (c == CH_MINUS || is_digit(c)) begin
							phase_d = PH_NUM_INT;
						end else begin
							phase_d    = PH_ERROR;
							pend_err_d = ERR_VALUE;
						end
					end
				end
				PH_STR: begin
					if (c == CH_BSLASH)
						phase_d = PH_STR_ESC;
					else if (c == CH_QUOTE)
						phase_d = PH_TRAIL;
				end
				PH_STR_ESC: phase_d = PH_STR;
				PH_CONT: begin
					if (c == CH_QUOTE) begin
						phase_d = PH_CSTR;
					end else if (c == open_c) begin
						if (depth_q >= MAX_CNT) begin
							phase_d    = PH_ERROR;
							pend_err_d = ERR_DEPTH;
						end else begin
							depth_d = depth_q + CNT_ONE;
						end
					end else if (c == close_c) begin
						if (depth_q <= CNT_ONE) begin
							depth_d = '0;
							phase_d = PH_TRAIL;
						end else begin
							depth_d = depth_q - CNT_ONE;
						end
					end
				end
				PH_CSTR: begin
					if (c == CH_BSLASH)
						phase_d = PH_CSTR_ESC;
					else if (c == CH_QUOTE)
						phase_d = PH_CONT;
				end
				PH_CSTR_ESC: phase_d = PH_CSTR;
				PH_LIT: begin
					if (lit_pos_q >= lit_len(lit_ch_q) || c != lit_char(lit_ch_q, lit_pos_q)) begin
						phase_d    = PH_ERROR;
						pend_err_d = ERR_VALUE;
					end else begin
						lit_pos_d = lit_pos_q + 3'd1;
						if (lit_pos_q + 3'd1 >= lit_len(lit_ch_q))
							phase_d = PH_TRAIL;
					end
				end
				PH_NUM_INT, PH_NUM_FRAC, PH_NUM_EXPS, PH_NUM_EXP, PH_TRAIL: begin
					// a byte that cannot continue the number must be whitespace
					if (phase_q == PH_NUM_INT && is_digit(c)) begin
						phase_d = PH_NUM_INT;
					end else if (phase_q == PH_NUM_INT && c == CH_DOT) begin
						phase_d = PH_NUM_FRAC;
					end else if (phase_q == PH_NUM_FRAC && is_digit(c)) begin
						phase_d = PH_NUM_FRAC;
					end else if ((phase_q == PH_NUM_INT || phase_q == PH_NUM_FRAC)
					             && (c == CH_E_LO || c == CH_E_UP)) begin
						phase_d = PH_NUM_EXPS;
					end else if (phase_q == PH_NUM_EXPS
					             && (c == CH_PLUS || c == CH_MINUS || is_digit(c))) begin
						phase_d = PH_NUM_EXP;
					end else if (phase_q == PH_NUM_EXP && is_digit(c)) begin
						phase_d = PH_NUM_EXP;
					end else if (is_ws(c)) begin
						phase_d = PH_TRAIL;
					end else begin
						phase_d    = PH_ERROR;
						pend_err_d = ERR_EXTRA;
					end
				end
				default: phase_d = PH_ERROR;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LEAD;
			is_array_q <= 1'b0;
			depth_q    <= '0;
			lit_ch_q   <= LIT_TRUE;
			lit_pos_q  <= '0;
			pend_err_q <= ERR_OK;
		end else if (in_fire) begin
			phase_q    <= phase_d;
			is_array_q <= is_array_d;
			depth_q    <= depth_d;
			lit_ch_q   <= lit_ch_d;
			lit_pos_q  <= lit_pos_d;
			pend_err_q <= pend_err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && term) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// verdict payload, loaded with the terminator transaction
	always_ff @(posedge clk) begin
		if (in_fire && term) begin
			is_valid_q   <= (final_code == ERR_OK);
			error_code_q <= final_code;
		end
	end

	assign out_valid  = out_valid_q;
	assign is_valid   = is_valid_q;
	assign error_code = error_code_q;

	a_verdict_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_valid == (error_code == ERR_OK)) && (error_code <= ERR_DEPTH))
		else $error("verdict flag disagrees with error code");

	a_error_latched: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERROR) == (pend_err_q != ERR_OK))
		else $error("pending error out of step with error phase");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= MAX_CNT)
		else $error("nesting count beyond maximum depth");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (end_of_text || text_byte == CH_NUL)
		|=> out_valid && phase_q == PH_LEAD && depth_q == '0)
		else $error("scanner did not restart after terminator");

endmodule

>>> tb/jvsc_verdict_check.sv
module jvsc_verdict_check
	import jvsc_pkg::*;
#(
	parameter int unsigned DEPTH_LIMIT = MAX_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  in_ready,
	input  byte_t text_byte,
	input  logic  end_of_text,
	input  logic  out_valid,
	input  logic  out_ready,
	input  logic  is_valid,
	input  err_t  error_code,
	output int    mismatches,
	output int    outstanding
);

	typedef struct packed {
		logic ok;
		err_t code;
	} verdict_t;

	typedef enum logic [3:0] {
		SCAN_LEAD,
		SCAN_STR,
		SCAN_STR_ESC,
		SCAN_CONT,
		SCAN_CSTR,
		SCAN_CSTR_ESC,
		SCAN_LIT,
		SCAN_INT,
		SCAN_FRAC,
		SCAN_EXP_SIGN,
		SCAN_EXP,
		SCAN_TRAIL,
		SCAN_ERROR
	} scan_t;

	verdict_t    verdict_q[$];
	scan_t       phase;
	logic        in_array;
	int unsigned depth;
	lit_choice_t word;
	int unsigned word_pos;
	err_t        first_err;
	string       spelling[3] = '{"true", "false", "null"};

	function automatic logic blank(input byte_t c);
		case (c)
			8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic decimal(input byte_t c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic void clear_scan();
		phase     = SCAN_LEAD;
		in_array  = 1'b0;
		depth     = 0;
		word      = LIT_TRUE;
		word_pos  = 0;
		first_err = ERR_OK;
	endfunction

	function automatic void raise_error(input err_t code);
		first_err = code;
		phase     = SCAN_ERROR;
	endfunction

	function automatic void after_value(input byte_t c);
		if (blank(c))
			phase = SCAN_TRAIL;
		else
			raise_error(ERR_EXTRA);
	endfunction

	function automatic err_t closing_code();
		case (phase)
			SCAN_LEAD: return ERR_EMPTY;
			SCAN_STR, SCAN_STR_ESC, SCAN_CONT, SCAN_CSTR, SCAN_CSTR_ESC: return ERR_UNTERM;
			SCAN_LIT: return ERR_VALUE;
			SCAN_INT, SCAN_FRAC, SCAN_EXP_SIGN, SCAN_EXP, SCAN_TRAIL: return ERR_OK;
			default: return first_err;
		endcase
	endfunction

	function automatic void scan_transaction(input byte_t c, input logic eot);
		verdict_t v;
		byte_t    open_c;
		byte_t    close_c;
		string    w;
		if (eot || c == CH_NUL) begin
			v.code = closing_code();
			v.ok   = (v.code == ERR_OK);
			verdict_q.push_back(v);
			clear_scan();
			return;
		end
		case (phase)
			SCAN_LEAD: begin
				if (!blank(c)) begin
					case (c)
						CH_QUOTE: phase = SCAN_STR;
						CH_LBRACE: begin
							in_array = 1'b0;
							depth    = 1;
							phase    = SCAN_CONT;
						end
						CH_LBRACK: begin
							in_array = 1'b1;
							depth    = 1;
							phase    = SCAN_CONT;
						end
						CH_T: begin
							word     = LIT_TRUE;
							word_pos = 1;
							phase    = SCAN_LIT;
						end
						CH_F: begin
							word     = LIT_FALSE;
							word_pos = 1;
							phase    = SCAN_LIT;
						end
						CH_N: begin
							word     = LIT_NULL;
							word_pos = 1;
							phase    = SCAN_LIT;
						end
						default: begin
							if (c == CH_MINUS || decimal(c))
								phase = SCAN_INT;
							else
								raise_error(ERR_VALUE);
						end
					endcase
				end
			end
			SCAN_STR: begin
				if (c == CH_BSLASH)
					phase = SCAN_STR_ESC;
				else if (c == CH_QUOTE)
					phase = SCAN_TRAIL;
			end
			SCAN_STR_ESC: phase = SCAN_STR;
			SCAN_CONT: begin
				// only the container's own bracket kind moves the depth
				open_c  = in_array ? CH_LBRACK : CH_LBRACE;
				close_c = in_array ? CH_RBRACK : CH_RBRACE;
				if (c == CH_QUOTE) begin
					phase = SCAN_CSTR;
				end else if (c == open_c) begin
					if (depth >= DEPTH_LIMIT)
						raise_error(ERR_DEPTH);
					else
						depth++;
				end else if (c == close_c) begin
					if (depth <= 1) begin
						depth = 0;
						phase = SCAN_TRAIL;
					end else begin
						depth--;
					end
				end
			end
			SCAN_CSTR: begin
				if (c == CH_BSLASH)
					phase = SCAN_CSTR_ESC;
				else if (c == CH_QUOTE)
					phase = SCAN_CONT;
			end
			SCAN_CSTR_ESC: phase = SCAN_CSTR;
			SCAN_LIT: begin
				w = spelling[word];
				if (word_pos >= w.len() || c != w[word_pos]) begin
					raise_error(ERR_VALUE);
				end else begin
					word_pos++;
					if (word_pos >= w.len())
						phase = SCAN_TRAIL;
				end
			end
			SCAN_INT: begin
				if (!decimal(c)) begin
					if (c == CH_DOT)
						phase = SCAN_FRAC;
					else if (c == CH_E_LO || c == CH_E_UP)
						phase = SCAN_EXP_SIGN;
					else
						after_value(c);
				end
			end
			SCAN_FRAC: begin
				if (!decimal(c)) begin
					if (c == CH_E_LO || c == CH_E_UP)
						phase = SCAN_EXP_SIGN;
					else
						after_value(c);
				end
			end
			SCAN_EXP_SIGN: begin
				if (c == CH_PLUS || c == CH_MINUS || decimal(c))
					phase = SCAN_EXP;
				else
					after_value(c);
			end
			SCAN_EXP: begin
				if (!decimal(c))
					after_value(c);
			end
			SCAN_TRAIL: after_value(c);
			default: ; // absorb everything after the first error
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t want;
		if (!arst_n) begin
			clear_scan();
			verdict_q.delete();
			outstanding = 0;
		end else begin
			// compare before predicting: a verdict never leaves in the cycle of its terminator
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected verdict: is_valid=%0b error_code=%0d",
							is_valid, error_code);
				end else begin
					want = verdict_q.pop_front();
					if (is_valid !== want.ok || error_code !== want.code) begin
						mismatches++;
						if (mismatches <= 10)
							$display("verdict mismatch: expected is_valid=%0b error_code=%0d, got is_valid=%0b error_code=%0d",
								want.ok, want.code, is_valid, error_code);
					end
				end
			end
			if (in_valid && in_ready)
				scan_transaction(text_byte, end_of_text);
			outstanding = verdict_q.size();
		end
	end

endmodule

>>> tb/testbench.sv
module testbench;
	import jvsc_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_OFF    = 160;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	byte_t text_byte;
	logic  end_of_text;
	logic  out_valid;
	logic  out_ready;
	logic  is_valid;
	err_t  error_code;

	int    mismatches;
	int    outstanding;
	int    send_gap_pct;
	int    take_gap_pct;
	int    hold_request;
	int    items_sent;
	int    quiet_cycles;
	byte_t doc_bytes[$];
	string words[3] = '{"true", "false", "null"};

	json_value_structure_checker_top #(
		.MAX_DEPTH(MAX_DEPTH_DEF)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.is_valid   (is_valid),
		.error_code (error_code)
	);

	jvsc_verdict_check #(
		.DEPTH_LIMIT(MAX_DEPTH_DEF)
	) i_verdict_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.is_valid   (is_valid),
		.error_code (error_code),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("** json_value_structure_checker_top: FAILED **");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// verdict side: random stalls, plus a long hold when requested
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= take_gap_pct);
			end
		end
	end

	function automatic void put_byte(input byte_t b);
		doc_bytes.push_back(b);
	endfunction

	function automatic void put_blanks();
		byte_t pool[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
		repeat ($urandom_range(2)) put_byte(pool[$urandom_range(5)]);
	endfunction

	function automatic void load_text(input string s);
		doc_bytes.delete();
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endfunction

	function automatic void gen_string();
		byte_t c;
		put_byte(CH_QUOTE);
		repeat ($urandom_range(5)) begin
			if ($urandom_range(3) == 0) begin
				put_byte(CH_BSLASH);
				put_byte(byte_t'($urandom_range(1, 255)));
			end else begin
				c = byte_t'($urandom_range(32, 126));
				if (c == CH_QUOTE || c == CH_BSLASH)
					c = 8'h61;
				put_byte(c);
			end
		end
		put_byte(CH_QUOTE);
	endfunction

	function automatic void gen_number();
		logic minus;
		minus = $urandom_range(2) == 0;
		if (minus)
			put_byte(CH_MINUS);
		repeat ($urandom_range(minus ? 0 : 1, 3))
			put_byte(byte_t'(8'h30 + $urandom_range(9)));
		if ($urandom_range(2) == 0) begin
			put_byte(CH_DOT);
			repeat ($urandom_range(2)) put_byte(byte_t'(8'h30 + $urandom_range(9)));
		end
		if ($urandom_range(2) == 0) begin
			put_byte($urandom_range(1) ? CH_E_LO : CH_E_UP);
			if ($urandom_range(1))
				put_byte($urandom_range(1) ? CH_PLUS : CH_MINUS);
			repeat ($urandom_range(2)) put_byte(byte_t'(8'h30 + $urandom_range(9)));
		end
	endfunction

	function automatic void gen_literal();
		string w;
		w = words[$urandom_range(2)];
		for (int i = 0; i < w.len(); i++)
			put_byte(w[i]);
	endfunction

	function automatic void gen_container(input logic arr, input int level);
		byte_t sep[3] = '{8'h2C, 8'h3A, 8'h20};
		put_byte(arr ? CH_LBRACK : CH_LBRACE);
		repeat ($urandom_range(4)) begin
			case ($urandom_range(5))
				0: if (level < 3) gen_container(arr, level + 1);
				1: gen_string();
				2: gen_number();
				3: gen_literal();
				// the other bracket kind is plain content here
				4: put_byte(arr ? ($urandom_range(1) ? CH_LBRACE : CH_RBRACE)
					: ($urandom_range(1) ? CH_LBRACK : CH_RBRACK));
				default: put_byte(sep[$urandom_range(2)]);
			endcase
		end
		put_byte(arr ? CH_RBRACK : CH_RBRACE);
	endfunction

	function automatic void gen_value();
		case ($urandom_range(5))
			0: gen_string();
			1, 2: gen_container($urandom_range(1) == 1, 0);
			3: gen_literal();
			default: gen_number();
		endcase
	endfunction

	function automatic void build_random_doc();
		int pick;
		int at;
		doc_bytes.delete();
		pick = $urandom_range(99);
		if (pick < 10) begin
			repeat ($urandom_range(1, 8)) put_byte(byte_t'($urandom_range(1, 255)));
		end else begin
			put_blanks();
			gen_value();
			put_blanks();
			if (pick >= 75) begin
				at = $urandom_range(doc_bytes.size() - 1);
				case ($urandom_range(2))
					0: while (doc_bytes.size() > at) void'(doc_bytes.pop_back());
					1: doc_bytes[at] = byte_t'($urandom_range(1, 255));
					default: put_byte(byte_t'($urandom_range(33, 255)));
				endcase
			end
		end
	endfunction

	// one transaction on the byte side; called and returns at a falling edge
	task automatic offer(input byte_t b, input logic eot);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		text_byte   <= b;
		end_of_text <= eot;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_doc(input logic zero_end);
		foreach (doc_bytes[i])
			offer(doc_bytes[i], 1'b0);
		if (zero_end)
			offer(CH_NUL, 1'b0);
		else
			offer(byte_t'($urandom_range(255)), 1'b1);
	endtask

	task automatic random_docs(input int stop_at);
		while (items_sent < stop_at) begin
			build_random_doc();
			send_doc($urandom_range(4) == 0);
		end
	endtask

	task automatic deep_doc(input byte_t open_c, input int count);
		doc_bytes.delete();
		repeat (count) put_byte(open_c);
		send_doc(1'b0);
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		text_byte    = '0;
		end_of_text  = 1'b0;
		send_gap_pct = 18;
		take_gap_pct = 78;
		hold_request = 0;
		items_sent   = 0;
		quiet_cycles = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// blank text, ending with an all-ones ignored byte, then with a zero byte
		offer(8'hFF, 1'b1);
		load_text(" \t");
		send_doc(1'b1);
		// string cut inside an escape, container left open
		load_text("\"a\\");
		send_doc(1'b0);
		load_text("[{");
		send_doc(1'b0);
		// literal cut short, literal misspelled with later bytes absorbed
		load_text("nul");
		send_doc(1'b1);
		load_text("tx1");
		send_doc(1'b0);
		// lenient number: minus, empty fraction, empty exponent
		load_text("-.E+ ");
		send_doc(1'b0);

		// full depth is fine, one level more overflows
		deep_doc(CH_LBRACK, MAX_DEPTH_DEF);
		deep_doc(CH_LBRACE, MAX_DEPTH_DEF + 1);
		random_docs(700);

		// drain before switching idle rates
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		send_gap_pct = 78;
		take_gap_pct = 18;
		random_docs(1080);

		send_gap_pct = 0;
		take_gap_pct = 0;
		// hold the verdict side while short documents keep coming
		hold_request = HOLD_OFF;
		repeat (12) begin
			load_text("7");
			send_doc(1'b0);
		end
		random_docs(1450);

		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("** json_value_structure_checker_top: PASSED **");
		else
			$display("** json_value_structure_checker_top: FAILED **");
		$finish;
	end

endmodule
